// ===== src/mbhv_pkg.sv =====
// Shared types, constants and the CRC byte function of the MacBinary header validator.
package mbhv_pkg;

    localparam int FILE_SIZE_W = 48;
    localparam int LEN_W       = 32;
    localparam int OFFS_W      = 33;
    localparam int END_W       = 34;
    localparam int IDX_W       = 7;
    localparam int CRC_W       = 16;
    localparam int ALIGN_SHIFT = 7;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] NAME_MAX_LEN = 8'd63;
    localparam logic [7:0] VERSION_MAX  = 8'd129;

    localparam logic [IDX_W-1:0] IDX_OLD_VERSION = 7'd0;
    localparam logic [IDX_W-1:0] IDX_NAME_LEN    = 7'd1;
    localparam logic [IDX_W-1:0] IDX_ZERO_A      = 7'd74;
    localparam logic [IDX_W-1:0] IDX_ZERO_B      = 7'd82;
    localparam logic [IDX_W-1:0] IDX_DLEN_FIRST  = 7'd83;
    localparam logic [IDX_W-1:0] IDX_DLEN_LAST   = 7'd86;
    localparam logic [IDX_W-1:0] IDX_RLEN_FIRST  = 7'd87;
    localparam logic [IDX_W-1:0] IDX_RLEN_LAST   = 7'd90;
    localparam logic [IDX_W-1:0] IDX_ROFF_CALC   = 7'd91;
    localparam logic [IDX_W-1:0] IDX_REND_CALC   = 7'd92;
    localparam logic [IDX_W-1:0] IDX_MIN_VERSION = 7'd123;
    localparam logic [IDX_W-1:0] IDX_CRC_SPAN    = 7'd124;
    localparam logic [IDX_W-1:0] IDX_CHK_HI      = 7'd124;
    localparam logic [IDX_W-1:0] IDX_CHK_LO      = 7'd125;
    localparam logic [IDX_W-1:0] IDX_FINAL       = 7'd127;

    localparam logic [OFFS_W-1:0] DFORK_START = 33'd128;
    localparam logic [OFFS_W-1:0] ALIGN_MASK  = 33'd127;

    typedef enum logic [1:0] {
        ST_VALID  = 2'd0,
        ST_FORMAT = 2'd1,
        ST_BOUNDS = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]             header_byte;
        logic [FILE_SIZE_W-1:0] file_size;
        logic                   end_of_data;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [LEN_W-1:0]  dfork_len;
        logic [OFFS_W-1:0] rfork_base;
        logic [LEN_W-1:0]  rfork_len;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] acc, logic [7:0] b);
        logic [CRC_W-1:0] c;
        logic [7:0]       d;
        c = acc;
        d = b;
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1] ^ d[7]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/macbinary_header_validator.sv =====
// Top level of the MacBinary II header validator: input register, parser and result register.
// The block takes one header byte per cycle, also across back-to-back headers, unless a finished
// result waits on the sink; a result transaction is presented in the cycle after the parser takes
// the byte at offset 127, or an earlier byte that carries tlast, and the result register lets the
// next header start while that result waits. The CRC-16 update of bytes below offset 124 and the
// per-byte checks are combinational between the input register and header state; the fork end
// sums form while bytes 91 and 92 pass, so the final bounds decision is three parallel compares.
module macbinary_header_validator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,   // header_byte [7:0], file_size [55:8]
    input  logic          s_tlast,   // end_of_data
    output logic          m_tvalid,
    input  logic          m_tready,
    // Data fork length [31:0], resource fork offset [64:32], resource fork length [96:65].
    output logic [103:0]  m_tdata,
    output logic [1:0]    m_tuser    // status
);

    mbhv_pkg::item_t   s_item;
    mbhv_pkg::item_t   item;
    mbhv_pkg::result_t res;
    mbhv_pkg::result_t m_res;
    logic              item_valid;
    logic              item_take;
    logic              out_free;
    logic              res_load;

    assign s_item.header_byte = s_tdata[7:0];
    assign s_item.file_size   = s_tdata[55:8];
    assign s_item.end_of_data = s_tlast;

    mbhv_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mbhv_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res)
    );

    mbhv_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tuser = m_res.status;
    assign m_tdata = {7'd0, m_res.rfork_len, m_res.rfork_base, m_res.dfork_len};

    // A failed header carries no fork information.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != mbhv_pkg::ST_VALID |-> m_tdata == '0)
        else $error("failed header result carries nonzero fork fields");

    // A valid header places the resource fork on a 128-byte boundary past the header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mbhv_pkg::ST_VALID |->
            m_tdata[38:32] == 7'd0 && m_tdata[64:32] != 33'd0)
        else $error("resource fork offset is misaligned");

    // A valid header's resource fork never starts before the data fork ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mbhv_pkg::ST_VALID |->
            {1'b0, m_tdata[64:32]} >= {2'b00, m_tdata[31:0]} + 34'd128)
        else $error("resource fork overlaps the data fork");

    // Reset leaves the block ready for input with no result pending.
    assert property (@(posedge aclk) !$past(aresetn) |-> s_tready && !m_tvalid)
        else $error("block not idle after reset");

endmodule

// ===== src/mbhv_in_stage.sv =====
// Input register that holds one accepted header byte until the parser consumes it.
module mbhv_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mbhv_pkg::item_t    s_item,
    output logic               item_valid,
    output mbhv_pkg::item_t    item,
    input  logic               item_take
);

    logic            valid_reg;
    logic            valid_next;
    mbhv_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== src/mbhv_parser.sv =====
// Header state, per-byte checks, CRC update and final status decision.
module mbhv_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  mbhv_pkg::item_t     item,
    output logic                item_take,
    input  logic                out_free,
    output logic                res_load,
    output mbhv_pkg::result_t   res
);

    logic [mbhv_pkg::IDX_W-1:0]  idx_reg,   idx_next;
    logic [mbhv_pkg::CRC_W-1:0]  crc_reg,   crc_next;
    logic                        fault_reg, fault_next;
    logic [mbhv_pkg::CRC_W-1:0]  chk_reg,   chk_next;
    logic [mbhv_pkg::LEN_W-1:0]  dlen_reg,  dlen_next;
    logic [mbhv_pkg::LEN_W-1:0]  rlen_reg,  rlen_next;
    logic [mbhv_pkg::OFFS_W-1:0] dend_reg,  dend_next;
    logic [mbhv_pkg::OFFS_W-1:0] roff_reg,  roff_next;
    logic [mbhv_pkg::END_W-1:0]  rend_reg,  rend_next;

    logic [mbhv_pkg::OFFS_W-1:0] roff_sum;
    logic [7:0]                  b;
    logic                        is_final;
    logic                        emit;
    logic                        bounds_bad;

    assign b        = item.header_byte;
    assign is_final = (idx_reg == mbhv_pkg::IDX_FINAL);
    assign emit     = is_final || item.end_of_data;
    assign item_take = item_valid && (!emit || out_free);
    assign res_load  = item_take && emit;

    assign roff_sum = {1'b0, dlen_reg} + mbhv_pkg::DFORK_START + mbhv_pkg::ALIGN_MASK;

    assign bounds_bad =
        ({{(mbhv_pkg::FILE_SIZE_W-mbhv_pkg::OFFS_W){1'b0}}, dend_reg} > item.file_size) ||
        ({{(mbhv_pkg::FILE_SIZE_W-mbhv_pkg::OFFS_W){1'b0}}, roff_reg} > item.file_size) ||
        ({{(mbhv_pkg::FILE_SIZE_W-mbhv_pkg::END_W){1'b0}}, rend_reg} > item.file_size);

    always_comb begin
        idx_next   = idx_reg + 7'd1;
        crc_next   = crc_reg;
        fault_next = fault_reg;
        chk_next   = chk_reg;
        dlen_next  = dlen_reg;
        rlen_next  = rlen_reg;
        dend_next  = dend_reg;
        roff_next  = roff_reg;
        rend_next  = rend_reg;

        if (idx_reg < mbhv_pkg::IDX_CRC_SPAN) begin
            crc_next = mbhv_pkg::crc_byte(crc_reg, b);
        end
        if ((idx_reg == mbhv_pkg::IDX_OLD_VERSION || idx_reg == mbhv_pkg::IDX_ZERO_A ||
             idx_reg == mbhv_pkg::IDX_ZERO_B) && b != 8'd0) begin
            fault_next = 1'b1;
        end
        if (idx_reg == mbhv_pkg::IDX_NAME_LEN && b > mbhv_pkg::NAME_MAX_LEN) begin
            fault_next = 1'b1;
        end
        if (idx_reg == mbhv_pkg::IDX_MIN_VERSION && b > mbhv_pkg::VERSION_MAX) begin
            fault_next = 1'b1;
        end
        if (idx_reg == mbhv_pkg::IDX_CHK_HI || idx_reg == mbhv_pkg::IDX_CHK_LO) begin
            chk_next = {chk_reg[7:0], b};
        end
        if (idx_reg >= mbhv_pkg::IDX_DLEN_FIRST && idx_reg <= mbhv_pkg::IDX_DLEN_LAST) begin
            dlen_next = {dlen_reg[mbhv_pkg::LEN_W-9:0], b};
        end
        if (idx_reg >= mbhv_pkg::IDX_RLEN_FIRST && idx_reg <= mbhv_pkg::IDX_RLEN_LAST) begin
            rlen_next = {rlen_reg[mbhv_pkg::LEN_W-9:0], b};
        end
        if (idx_reg == mbhv_pkg::IDX_ROFF_CALC) begin
            dend_next = {1'b0, dlen_reg} + mbhv_pkg::DFORK_START;
            roff_next = {roff_sum[mbhv_pkg::OFFS_W-1:mbhv_pkg::ALIGN_SHIFT],
                         {mbhv_pkg::ALIGN_SHIFT{1'b0}}};
        end
        if (idx_reg == mbhv_pkg::IDX_REND_CALC) begin
            rend_next = {1'b0, roff_reg} + {2'b00, rlen_reg};
        end

        if (emit) begin
            idx_next   = '0;
            crc_next   = '0;
            fault_next = 1'b0;
            chk_next   = '0;
            dlen_next  = '0;
            rlen_next  = '0;
            dend_next  = '0;
            roff_next  = '0;
            rend_next  = '0;
        end
    end

    always_comb begin
        res = '0;
        if (!is_final || fault_reg || chk_reg != crc_reg) begin
            res.status = mbhv_pkg::ST_FORMAT;
        end else if (bounds_bad) begin
            res.status = mbhv_pkg::ST_BOUNDS;
        end else begin
            res.status     = mbhv_pkg::ST_VALID;
            res.dfork_len  = dlen_reg;
            res.rfork_base = roff_reg;
            res.rfork_len  = rlen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            crc_reg   <= '0;
            fault_reg <= 1'b0;
            chk_reg   <= '0;
            dlen_reg  <= '0;
            rlen_reg  <= '0;
            dend_reg  <= '0;
            roff_reg  <= '0;
            rend_reg  <= '0;
        end else if (item_take) begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            fault_reg <= fault_next;
            chk_reg   <= chk_next;
            dlen_reg  <= dlen_next;
            rlen_reg  <= rlen_next;
            dend_reg  <= dend_next;
            roff_reg  <= roff_next;
            rend_reg  <= rend_next;
        end
    end

endmodule

// ===== src/mbhv_out_stage.sv =====
// Result register that holds one result transaction until the sink takes it.
module mbhv_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_load,
    input  mbhv_pkg::result_t   res,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mbhv_pkg::result_t   m_res
);

    logic              valid_reg;
    logic              valid_next;
    mbhv_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

endmodule
